[design/stable_matching_enumerator_macros.svh]
// Assertion macros for the stable matching enumerator.
`ifndef STABLE_MATCHING_ENUMERATOR_MACROS_SVH
`define STABLE_MATCHING_ENUMERATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SME_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sme: assertion failed");
// Next-cycle implication.
`define SME_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sme: assertion failed");
`else
`define SME_ASSERT_IMP(label, clk, rst, ante, cons)
`define SME_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[design/sme_pkg.sv]
// Shared types and constants of the stable matching enumerator.
package sme_pkg;

   localparam int PAIRS_DEFAULT = 8;
   localparam int IDX_W         = 4;
   localparam int RANK_W        = 4;
   localparam int PAIRING_W     = 24;
   localparam int COUNT_W       = 16;

   localparam logic [1:0] CMD_WR_MAN   = 2'd0;
   localparam logic [1:0] CMD_WR_WOMAN = 2'd1;
   localparam logic [1:0] CMD_RESTART  = 2'd2;
   localparam logic [1:0] CMD_FIND     = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [IDX_W-1:0]  man_index;
      logic [IDX_W-1:0]  woman_index;
      logic [RANK_W-1:0] rank_value;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [PAIRING_W-1:0] pairing;
      logic [COUNT_W-1:0]   solution_count;
   } rsp_type;

   // Table write request
   typedef struct packed {
      logic              man_we;
      logic              woman_we;
      logic [IDX_W-1:0]  man_idx;
      logic [IDX_W-1:0]  woman_idx;
      logic [RANK_W-1:0] value;
   } rank_wr_type;

   // Read addresses: man table (man, woman), woman table (woman, man)
   typedef struct packed {
      logic [IDX_W-1:0] man_m;
      logic [IDX_W-1:0] man_w;
      logic [IDX_W-1:0] wom_w;
      logic [IDX_W-1:0] wom_m;
   } rank_rd_type;

endpackage

[design/stable_matching_enumerator.sv]
// Top level: resumable backtracking search over stable perfect matchings.
//
//   port group | dir | handshake          | beat payload
//   -----------+-----+--------------------+------------------------------------
//   req_       | in  | req_valid/req_stall | cmd, man_index, woman_index, rank
//   rsp_       | out | rsp_valid/rsp_stall | found, pairing, solution_count
//
// Writes and restarts produce no beat.
// Find-next walks the search tree: each level step makes one compare pass per
// earlier man (four rank-memory reads each), so the length of one find is set by
// the preference data.
// Reset (synchronous, active high) clears the search; rank tables keep contents.
// req_stall is high for the whole search; a pending rsp beat waits in the output
// register while new write or restart beats are still taken.
`include "stable_matching_enumerator_macros.svh"

module stable_matching_enumerator #(
   parameter int PAIRS = sme_pkg::PAIRS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sme_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sme_pkg::rsp_type rsp_data
);
   import sme_pkg::*;

   localparam int IW    = $clog2(PAIRS);      // man / woman index
   localparam int PW    = $clog2(PAIRS + 1);  // partner slot, PAIRS = exhausted
   localparam int PACKW = PAIRS * IW;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ADVANCE = 3'd1;  // bump partner at current level
   localparam logic [2:0] S_LEVEL   = 3'd2;  // inspect current level
   localparam logic [2:0] S_CHECK   = 3'd3;  // blocking-pair test vs earlier men
   localparam logic [2:0] S_EMIT    = 3'd4;  // load result beat

   // check phases: each issues one man-table and one woman-table read
   localparam logic [2:0] PH_A = 3'd0;  // m(i,w), w(w,i); also the taken test
   localparam logic [2:0] PH_B = 3'd1;  // m(i,v), w(w,lvl)
   localparam logic [2:0] PH_C = 3'd2;  // compare 1; m(lvl,v), w(v,lvl)
   localparam logic [2:0] PH_D = 3'd3;  // m(lvl,w), w(v,i)
   localparam logic [2:0] PH_E = 3'd4;  // compare 2

   logic [2:0]        state_ff, state_in;
   logic [2:0]        phase_ff, phase_in;
   logic [PW-1:0]     partner_ff [PAIRS];
   logic [PW-1:0]     partner_in [PAIRS];
   logic [PW-1:0]     level_ff, level_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW-1:0]     cur_w_ff, cur_w_in;
   logic [RANK_W-1:0] man_hold_ff, man_hold_in;
   logic [RANK_W-1:0] wom_hold_ff, wom_hold_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic              done_ff, done_in;
   logic              emit_found_ff, emit_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_accept;
   logic              rsp_load;
   logic [IW-1:0]     lvl_idx;
   logic [IW-1:0]     rd_idx;
   logic [PW-1:0]     partner_rd;
   logic [IW-1:0]     v_idx;
   logic [PW-1:0]     desc_lvl;
   logic              last_i;
   logic              cmp_hit;
   logic [PACKW-1:0]  pack;
   rank_wr_type       tbl_wr;
   rank_rd_type       tbl_rd;
   logic [RANK_W-1:0] man_rank;
   logic [RANK_W-1:0] woman_rank;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // single read port on the partner registers: man i while checking, else level
   assign lvl_idx    = level_ff[IW-1:0];
   assign rd_idx     = (state_ff == S_CHECK) ? i_ff : lvl_idx;
   assign partner_rd = partner_ff[rd_idx];
   assign v_idx      = partner_rd[IW-1:0];
   assign desc_lvl   = level_ff + PW'(1);
   assign last_i     = (PW'(i_ff) + PW'(1)) == level_ff;

   // shared compare unit: both halves of a blocking-pair test
   assign cmp_hit = (man_hold_ff < man_rank) && (wom_hold_ff < woman_rank);

   for (genvar m = 0; m < PAIRS; m++) begin : g_pack
      assign pack[m*IW +: IW] = partner_ff[m][IW-1:0];
   end

   // table writes straight from the request beat
   always_comb begin
      tbl_wr.man_we    = req_accept && (req_data.cmd == CMD_WR_MAN);
      tbl_wr.woman_we  = req_accept && (req_data.cmd == CMD_WR_WOMAN);
      tbl_wr.man_idx   = req_data.man_index;
      tbl_wr.woman_idx = req_data.woman_index;
      tbl_wr.value     = req_data.rank_value;
   end

   // read addresses for the current check phase (v = partner of man i)
   always_comb begin
      case (phase_ff)
         PH_B: begin
            tbl_rd.man_m = IDX_W'(i_ff);
            tbl_rd.man_w = IDX_W'(v_idx);
            tbl_rd.wom_w = IDX_W'(cur_w_ff);
            tbl_rd.wom_m = IDX_W'(lvl_idx);
         end
         PH_C: begin
            tbl_rd.man_m = IDX_W'(lvl_idx);
            tbl_rd.man_w = IDX_W'(v_idx);
            tbl_rd.wom_w = IDX_W'(v_idx);
            tbl_rd.wom_m = IDX_W'(lvl_idx);
         end
         PH_D: begin
            tbl_rd.man_m = IDX_W'(lvl_idx);
            tbl_rd.man_w = IDX_W'(cur_w_ff);
            tbl_rd.wom_w = IDX_W'(v_idx);
            tbl_rd.wom_m = IDX_W'(i_ff);
         end
         default: begin
            tbl_rd.man_m = IDX_W'(i_ff);
            tbl_rd.man_w = IDX_W'(cur_w_ff);
            tbl_rd.wom_w = IDX_W'(cur_w_ff);
            tbl_rd.wom_m = IDX_W'(i_ff);
         end
      endcase
   end

   sme_rank_tables #(
      .PAIRS(PAIRS)
   ) u_tables (
      .clock      (clock),
      .wr         (tbl_wr),
      .rd         (tbl_rd),
      .man_rank   (man_rank),
      .woman_rank (woman_rank)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      partner_in    = partner_ff;
      level_in      = level_ff;
      i_in          = i_ff;
      cur_w_in      = cur_w_ff;
      man_hold_in   = man_hold_ff;
      wom_hold_in   = wom_hold_ff;
      total_in      = total_ff;
      done_in       = done_ff;
      emit_found_in = emit_found_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_data.cmd)
                  CMD_RESTART: begin
                     for (int k = 0; k < PAIRS; k++) begin
                        partner_in[k] = '0;
                     end
                     level_in = '0;
                     total_in = '0;
                     done_in  = 1'b0;
                  end
                  CMD_FIND: begin
                     if (done_ff) begin
                        emit_found_in = 1'b0;
                        state_in      = S_EMIT;
                     end else if (level_ff == PW'(PAIRS)) begin
                        // resume after a reported matching: advance the last man
                        level_in = PW'(PAIRS - 1);
                        state_in = S_ADVANCE;
                     end else begin
                        state_in = S_LEVEL;
                     end
                  end
                  default: begin
                     // table writes handled by the write port
                  end
               endcase
            end
         end

         S_ADVANCE: begin
            partner_in[lvl_idx] = partner_rd + PW'(1);
            state_in            = S_LEVEL;
         end

         S_LEVEL: begin
            if (level_ff == PW'(PAIRS)) begin
               // every man placed: a stable matching
               if (total_ff != '1) begin
                  total_in = total_ff + COUNT_W'(1);
               end
               emit_found_in = 1'b1;
               state_in      = S_EMIT;
            end else if (partner_rd == PW'(PAIRS)) begin
               // candidates at this level used up: backtrack
               if (level_ff == '0) begin
                  done_in       = 1'b1;
                  emit_found_in = 1'b0;
                  state_in      = S_EMIT;
               end else begin
                  level_in = level_ff - PW'(1);
                  state_in = S_ADVANCE;
               end
            end else begin
               cur_w_in = partner_rd[IW-1:0];
               if (level_ff == '0) begin
                  // no earlier men, woman is always acceptable
                  level_in = desc_lvl;
                  if (desc_lvl != PW'(PAIRS)) begin
                     partner_in[desc_lvl[IW-1:0]] = '0;
                  end
               end else begin
                  i_in     = '0;
                  phase_in = PH_A;
                  state_in = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            case (phase_ff)
               PH_A: begin
                  if (v_idx == cur_w_ff) begin
                     partner_in[lvl_idx] = PW'(cur_w_ff) + PW'(1);
                     state_in            = S_LEVEL;
                  end else begin
                     phase_in = PH_B;
                  end
               end
               PH_B: begin
                  man_hold_in = man_rank;
                  wom_hold_in = woman_rank;
                  phase_in    = PH_C;
               end
               PH_C: begin
                  // man i and woman w prefer each other
                  if (cmp_hit) begin
                     partner_in[lvl_idx] = PW'(cur_w_ff) + PW'(1);
                     state_in            = S_LEVEL;
                  end else begin
                     phase_in = PH_D;
                  end
               end
               PH_D: begin
                  man_hold_in = man_rank;
                  wom_hold_in = woman_rank;
                  phase_in    = PH_E;
               end
               PH_E: begin
                  // current man and woman v prefer each other
                  if (cmp_hit) begin
                     partner_in[lvl_idx] = PW'(cur_w_ff) + PW'(1);
                     state_in            = S_LEVEL;
                  end else if (last_i) begin
                     level_in = desc_lvl;
                     if (desc_lvl != PW'(PAIRS)) begin
                        partner_in[desc_lvl[IW-1:0]] = '0;
                     end
                     state_in = S_LEVEL;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     phase_in = PH_A;
                  end
               end
               default: begin
                  phase_in = PH_A;
               end
            endcase
         end

         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.found          = emit_found_ff;
         rsp_in.pairing        = emit_found_ff ? PAIRING_W'(pack) : '0;
         rsp_in.solution_count = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_A;
         level_ff     <= '0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < PAIRS; k++) begin
            partner_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         partner_ff   <= partner_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      cur_w_ff      <= cur_w_in;
      man_hold_ff   <= man_hold_in;
      wom_hold_ff   <= wom_hold_in;
      emit_found_ff <= emit_found_in;
      rsp_ff        <= rsp_in;
   end

   `SME_ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != S_IDLE, req_stall)
   `SME_ASSERT_IMP(a_level_range, clock, reset, 1'b1, level_ff <= PW'(PAIRS))
   `SME_ASSERT_IMP(a_check_below, clock, reset, state_ff == S_CHECK, PW'(i_ff) < level_ff)
   `SME_ASSERT_IMP(a_done_at_root, clock, reset, done_ff, level_ff == '0)
   `SME_ASSERT_NXT(a_emit_valid, clock, reset, rsp_load, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

[design/sme_rank_tables.sv]
// Man and woman preference rank memories with registered read ports.
module sme_rank_tables #(
   parameter int PAIRS = sme_pkg::PAIRS_DEFAULT
) (
   input  logic                        clock,
   input  sme_pkg::rank_wr_type        wr,
   input  sme_pkg::rank_rd_type        rd,
   output logic [sme_pkg::RANK_W-1:0]  man_rank,
   output logic [sme_pkg::RANK_W-1:0]  woman_rank
);
   import sme_pkg::*;

   localparam int DEPTH = PAIRS * PAIRS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(PAIRS);

   logic [RANK_W-1:0] man_mem   [DEPTH];
   logic [RANK_W-1:0] woman_mem [DEPTH];
   logic              wr_in_range;
   logic [AW-1:0]     man_wr_addr;
   logic [AW-1:0]     woman_wr_addr;
   logic [AW-1:0]     man_rd_addr;
   logic [AW-1:0]     woman_rd_addr;

   // row-major: row * PAIRS + column
   function automatic logic [AW-1:0] tbl_addr(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] col);
      tbl_addr = AW'(row[IW-1:0]) * AW'(PAIRS) + AW'(col[IW-1:0]);
   endfunction

   assign wr_in_range = (5'(wr.man_idx) < 5'(PAIRS)) && (5'(wr.woman_idx) < 5'(PAIRS));
   assign man_wr_addr   = tbl_addr(wr.man_idx, wr.woman_idx);
   assign woman_wr_addr = tbl_addr(wr.woman_idx, wr.man_idx);
   assign man_rd_addr   = tbl_addr(rd.man_m, rd.man_w);
   assign woman_rd_addr = tbl_addr(rd.wom_w, rd.wom_m);

   always_ff @(posedge clock) begin
      if (wr.man_we && wr_in_range) begin
         man_mem[man_wr_addr] <= wr.value;
      end
      man_rank <= man_mem[man_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.woman_we && wr_in_range) begin
         woman_mem[woman_wr_addr] <= wr.value;
      end
      woman_rank <= woman_mem[woman_rd_addr];
   end

endmodule

[verif/stable_matching_enumerator_tb.sv]
// Self-checking testbench for the stable matching enumerator: queued stimulus, search predictor.
module stable_matching_enumerator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sme_pkg::*;

   localparam int PAIRS        = PAIRS_DEFAULT;
   // width of one woman index inside the packed pairing
   localparam int SLOT_W       = (PAIRS <= 2) ? 1 : $clog2(PAIRS);
   // random part only; the directed part above it adds about 275 beats
   localparam int RANDOM_ITEMS = 325;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   stable_matching_enumerator #(.PAIRS(PAIRS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the search hangs or a beat never shows up.
   initial begin
      #200ms;
      $display("stable_matching_enumerator verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Search predictor: own copy of the rank tables and the resumable
   // depth-first state. man_pref[m][w] is man m's rank of woman w,
   // woman_pref[w][m] is woman w's rank of man m.
   // ---------------------------------------------------------------
   logic [RANK_W-1:0]  man_pref   [PAIRS][PAIRS];
   logic [RANK_W-1:0]  woman_pref [PAIRS][PAIRS];
   int                 trial_woman [PAIRS+1] = '{default: 0};  // next woman to try per level
   int                 depth          = 0;
   logic [COUNT_W-1:0] matchings_seen = '0;
   bit                 tree_spent     = 1'b0;

   rsp_type matchings_due [$];   // predicted result beats, oldest first
   req_type req_backlog   [$];   // request beats not yet offered
   int      mismatches = 0;

   // Man lvl may take woman w if she is free and no earlier pair blocks.
   function automatic bit fits(int lvl, int w);
      int v;
      for (int i = 0; i < lvl; i++) begin
         v = trial_woman[i];
         if (v == w) return 1'b0;
         // man i and woman w would both rather be together
         if (man_pref[i][w] < man_pref[i][v] && woman_pref[w][i] < woman_pref[w][lvl])
            return 1'b0;
         // man lvl and woman v would both rather be together
         if (man_pref[lvl][v] < man_pref[lvl][w] && woman_pref[v][lvl] < woman_pref[v][i])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic advance_search(input req_type item);
      int          lvl;
      int          w;
      bit          hit;
      rsp_type     beat;
      logic [63:0] packed_pairs;
      case (item.cmd)
         CMD_WR_MAN, CMD_WR_WOMAN: begin
            // out-of-range indices are dropped by the block
            if (int'(item.man_index) < PAIRS && int'(item.woman_index) < PAIRS) begin
               if (item.cmd == CMD_WR_MAN)
                  man_pref[item.man_index][item.woman_index] = item.rank_value;
               else
                  woman_pref[item.woman_index][item.man_index] = item.rank_value;
            end
         end
         CMD_RESTART: begin
            foreach (trial_woman[i]) trial_woman[i] = 0;
            depth          = 0;
            matchings_seen = '0;
            tree_spent     = 1'b0;
         end
         default: begin
            beat = '0;
            hit  = 1'b0;
            if (!tree_spent) begin
               // step past the matching reported last time
               if (depth >= PAIRS) begin
                  depth = PAIRS - 1;
                  trial_woman[depth]++;
               end
               while (!hit && !tree_spent) begin
                  lvl = depth;
                  if (lvl >= PAIRS) begin
                     hit = 1'b1;
                  end else begin
                     w = trial_woman[lvl];
                     if (w >= PAIRS) begin
                        if (lvl == 0) begin
                           tree_spent = 1'b1;
                        end else begin
                           depth = lvl - 1;
                           trial_woman[lvl-1]++;
                        end
                     end else if (fits(lvl, w)) begin
                        depth = lvl + 1;
                        trial_woman[lvl+1] = 0;
                     end else begin
                        trial_woman[lvl] = w + 1;
                     end
                  end
               end
            end
            if (hit) begin
               packed_pairs = '0;
               for (int m = 0; m < PAIRS; m++)
                  packed_pairs |= 64'(trial_woman[m] & ((1 << SLOT_W) - 1)) << (m * SLOT_W);
               if (matchings_seen != '1) matchings_seen++;
               beat.found   = 1'b1;
               beat.pairing = packed_pairs[PAIRING_W-1:0];
            end
            beat.solution_count = matchings_seen;
            matchings_due.push_back(beat);
         end
      endcase
   endtask

   // Wait cycles per beat; now and then a calm stretch with no waiting at all.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
      return $urandom_range(0, 5);
   endfunction

   function automatic void queue_beat(logic [1:0] cmd, int m, int w, int r);
      req_type b;
      b.cmd         = cmd;
      b.man_index   = m[IDX_W-1:0];
      b.woman_index = w[IDX_W-1:0];
      b.rank_value  = r[RANK_W-1:0];
      req_backlog.push_back(b);
   endfunction

   // ---------------------------------------------------------------
   // Request side: sampled at the rising edge, driven at the falling.
   // ---------------------------------------------------------------
   int req_gap  = 0;
   int req_calm = 0;
   bit req_took = 1'b0;   // the offered beat went in at the last rising edge

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         advance_search(req_data);
         req_took = 1'b1;
      end
   end

   always @(negedge clock) begin : req_driver
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (req_took) begin
         next_valid = 1'b0;
         req_took   = 1'b0;
      end
      // a held beat stays put; only an empty slot is refilled, after its gap
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (req_backlog.size() > 0) begin
            next_data  = req_backlog.pop_front();
            next_valid = 1'b1;
            req_gap    = draw_wait(req_calm);
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // ---------------------------------------------------------------
   // Result side: stall a drawn number of cycles per beat, then take it.
   // ---------------------------------------------------------------
   int rsp_hold = 0;
   int rsp_calm = 0;

   always @(negedge clock) begin
      rsp_stall <= rsp_valid && rsp_hold > 0;
      if (rsp_valid && rsp_hold > 0) rsp_hold--;
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold = draw_wait(rsp_calm);
         if (matchings_due.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            want = matchings_due.pop_front();
            if (rsp_data.found !== want.found) begin
               $display("%0t found: expected %0d actual %0d", $time, want.found, rsp_data.found);
               mismatches++;
            end
            if (rsp_data.pairing !== want.pairing) begin
               $display("%0t pairing: expected %06h actual %06h",
                        $time, want.pairing, rsp_data.pairing);
               mismatches++;
            end
            if (rsp_data.solution_count !== want.solution_count) begin
               $display("%0t solution_count: expected %0d actual %0d",
                        $time, want.solution_count, rsp_data.solution_count);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus. Every rank entry is written before the first find so
   // that no undefined table entry is ever read.
   // ---------------------------------------------------------------
   initial begin : stimulus
      int perm [PAIRS];
      int items;
      int base;
      int who;
      int pick;
      int swap;
      int n;

      // Tables full of ties: every permutation is stable.
      for (int m = 0; m < PAIRS; m++)
         for (int w = 0; w < PAIRS; w++) begin
            queue_beat(CMD_WR_MAN, m, w, 0);
            queue_beat(CMD_WR_WOMAN, m, w, 0);
         end
      repeat (3) queue_beat(CMD_FIND, 15, 15, 15);
      // worst rank mid-search, plus writes that must be dropped
      queue_beat(CMD_WR_MAN, 0, 0, 15);
      queue_beat(CMD_WR_MAN, 15, 15, 15);
      queue_beat(CMD_WR_WOMAN, 8, 2, 9);
      queue_beat(CMD_WR_MAN, 3, 12, 15);
      queue_beat(CMD_FIND, 0, 0, 0);
      queue_beat(CMD_RESTART, 15, 15, 15);
      queue_beat(CMD_FIND, 7, 8, 1);
      queue_beat(CMD_FIND, 8, 7, 14);

      // Everyone agrees on the order: the identity is the only stable matching.
      for (int m = 0; m < PAIRS; m++)
         for (int w = 0; w < PAIRS; w++) begin
            queue_beat(CMD_WR_MAN, m, w, w);
            queue_beat(CMD_WR_WOMAN, m, w, m);
         end
      queue_beat(CMD_RESTART, 0, 0, 0);
      repeat (3) queue_beat(CMD_FIND, 0, 0, 0);   // one match, then exhausted twice
      queue_beat(CMD_WR_MAN, PAIRS - 1, 0, 0);      // write after exhaustion
      queue_beat(CMD_FIND, 15, 0, 15);
      queue_beat(CMD_RESTART, 0, 15, 0);
      queue_beat(CMD_FIND, 0, 15, 0);

      // Random episodes: reshape some preferences, restart, walk the tree.
      items = 0;
      while (items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               // one whole row becomes a fresh strict order
               foreach (perm[i]) perm[i] = i;
               for (int i = PAIRS - 1; i > 0; i--) begin
                  pick       = $urandom_range(0, i);
                  swap       = perm[i];
                  perm[i]    = perm[pick];
                  perm[pick] = swap;
               end
               base = $urandom_range(0, 16 - PAIRS);
               who  = $urandom_range(0, PAIRS - 1);
               if ($urandom_range(0, 1)) begin
                  for (int i = 0; i < PAIRS; i++) queue_beat(CMD_WR_MAN, who, i, base + perm[i]);
               end else begin
                  for (int i = 0; i < PAIRS; i++) queue_beat(CMD_WR_WOMAN, i, who, base + perm[i]);
               end
               items += PAIRS;
            end
            2: begin
               n = $urandom_range(1, 6);
               repeat (n) queue_beat($urandom_range(0, 1) ? CMD_WR_MAN : CMD_WR_WOMAN,
                                     $urandom_range(0, PAIRS - 1), $urandom_range(0, PAIRS - 1),
                                     $urandom_range(0, 15));
               items += n;
            end
            default: ;
         endcase
         // noise: writes with an index past the table
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
               queue_beat(CMD_WR_MAN, $urandom_range(PAIRS, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15));
            else
               queue_beat(CMD_WR_WOMAN, $urandom_range(0, 15), $urandom_range(PAIRS, 15),
                          $urandom_range(0, 15));
            items++;
         end
         if ($urandom_range(0, 9) != 0) begin
            queue_beat(CMD_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15));
            items++;
         end
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) begin
            // occasionally change a rank between two finds
            if ($urandom_range(0, 7) == 0) begin
               queue_beat($urandom_range(0, 1) ? CMD_WR_MAN : CMD_WR_WOMAN,
                          $urandom_range(0, PAIRS - 1), $urandom_range(0, PAIRS - 1),
                          $urandom_range(0, 15));
               items++;
            end
            queue_beat(CMD_FIND, $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15));
            items++;
         end
      end

      // Drain: all beats offered and taken, all results back, then a quiet tail.
      while (req_backlog.size() > 0 || req_valid) @(posedge clock);
      while (matchings_due.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("stable_matching_enumerator verification clean");
      else
         $display("stable_matching_enumerator verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/sme_pkg.sv
design/sme_rank_tables.sv
design/stable_matching_enumerator.sv
verif/stable_matching_enumerator_tb.sv
